[rtl/core/gad_pkg.sv]
// Shared types and constants for the analog stick and trigger normalizer.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package gad_pkg;

   // One raw controller sample.
   typedef struct packed {
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
   } req_type;

   // One normalized result, Q1.15.
   typedef struct packed {
      logic signed [15:0] left_out_x;
      logic signed [15:0] left_out_y;
      logic signed [15:0] right_out_x;
      logic signed [15:0] right_out_y;
      logic [14:0]        left_trigger_out;
      logic [14:0]        right_trigger_out;
   } rsp_type;

   // Register file contents handed to the lanes.
   typedef struct packed {
      logic [14:0] left_dz;
      logic [14:0] right_dz;
      logic [7:0]  trig_th;
   } cfg_type;

   typedef enum logic [1:0] {
      CSR_LEFT_DZ  = 2'd0,
      CSR_RIGHT_DZ = 2'd1,
      CSR_TRIG_TH  = 2'd2
   } csr_index_type;

   localparam int CSR_WIDTH = 15;

   localparam logic [14:0] FULL_SCALE  = 15'd32767;
   localparam logic [14:0] DZ_MAX      = 15'd32766;
   localparam logic [7:0]  TRIG_MAX    = 8'd255;
   localparam logic [7:0]  TH_MAX      = 8'd254;
   localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
   localparam logic [7:0]  TRIG_TH_RST  = 8'd30;

   // Pipeline depths.
   localparam int SQRT_STAGES = 16;
   localparam int DIV_STAGES  = 15;
   // square, root, scale prep, scale divide, product, axis divide, sign
   localparam int STICK_LAT = 1 + SQRT_STAGES + 1 + DIV_STAGES + 1 + DIV_STAGES + 1;
   // trigger prep, divide and output register, then padding up to the stick
   localparam int TRIG_PAD  = STICK_LAT - DIV_STAGES - 2;
   // lanes plus the merge register
   localparam int PIPE_LAT  = STICK_LAT + 1;

endpackage

[rtl/core/gad_isqrt.sv]
// Pipelined floor square root of a 32-bit value, one root bit per stage.
// Depends on gad_pkg for the stage count.
`timescale 1ns / 1ps

module gad_isqrt import gad_pkg::*; (
   input  logic        clock,
   input  logic [31:0] radicand,
   output logic [15:0] root
);

   logic [31:0] rem_ff  [SQRT_STAGES];
   logic [15:0] root_ff [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      localparam int B = SQRT_STAGES - 1 - s;
      logic [31:0] rem_prev;
      logic [15:0] root_prev;
      logic [32:0] trial;
      logic        fits;
      logic [31:0] rem_in;
      logic [15:0] root_in;

      if (s == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign root_prev = root_ff[s-1];
      end

      // try setting root bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      assign trial   = ({17'b0, root_prev} << (B + 1)) | (33'd1 << (2 * B));
      assign fits    = {1'b0, rem_prev} >= trial;
      assign rem_in  = fits ? (rem_prev - trial[31:0]) : rem_prev;
      assign root_in = fits ? (root_prev | (16'd1 << B)) : root_prev;

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         root_ff[s] <= root_in;
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

[rtl/core/gad_div.sv]
// Pipelined restoring divider, one quotient bit per stage, 15-bit quotient.
// The dividend must stay below divisor * 2^15. Depends on gad_pkg.
`timescale 1ns / 1ps

module gad_div import gad_pkg::*; (
   input  logic        clock,
   input  logic [30:0] dividend,
   input  logic [15:0] divisor,
   output logic [14:0] quotient
);

   logic [30:0] rem_ff [DIV_STAGES];
   logic [15:0] dvs_ff [DIV_STAGES];
   logic [14:0] quo_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int B = DIV_STAGES - 1 - s;
      logic [30:0] rem_prev;
      logic [15:0] dvs_prev;
      logic [14:0] quo_prev;
      logic [30:0] shifted;
      logic        fits;
      logic [30:0] rem_in;
      logic [14:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_prev = dividend;
         assign dvs_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[s-1];
         assign dvs_prev = dvs_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      // subtract the shifted divisor where it fits
      assign shifted = {15'b0, dvs_prev} << B;
      assign fits    = rem_prev >= shifted;
      assign rem_in  = fits ? (rem_prev - shifted) : rem_prev;
      assign quo_in  = fits ? (quo_prev | (15'd1 << B)) : quo_prev;

      always_ff @(posedge clock) begin
         rem_ff[s] <= rem_in;
         dvs_ff[s] <= dvs_prev;
         quo_ff[s] <= quo_in;
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

[rtl/core/gad_stick_lane.sv]
// One stick lane: radius, radial deadzone scale and per-axis rescale.
// Depends on gad_pkg, gad_isqrt and gad_div.
`timescale 1ns / 1ps

module gad_stick_lane import gad_pkg::*; (
   input  logic               clock,
   input  logic signed [15:0] axis_x,
   input  logic signed [15:0] axis_y,
   input  logic [14:0]        deadzone,
   output logic signed [15:0] out_x,
   output logic signed [15:0] out_y
);

   // square and sum
   logic signed [31:0] xx, yy;
   logic [31:0]        sq_in, sq_ff;
   logic [15:0]        x1_ff, y1_ff;
   logic [14:0]        dz_in, dz1_ff;

   assign xx    = axis_x * axis_x;
   assign yy    = axis_y * axis_y;
   assign sq_in = $unsigned(xx) + $unsigned(yy);
   assign dz_in = (deadzone == FULL_SCALE) ? DZ_MAX : deadzone;

   always_ff @(posedge clock) begin
      sq_ff  <= sq_in;
      x1_ff  <= axis_x;
      y1_ff  <= axis_y;
      dz1_ff <= dz_in;
   end

   // radius
   logic [15:0] mag;
   gad_isqrt u_isqrt (.clock(clock), .radicand(sq_ff), .root(mag));

   logic [15:0] xr_ff  [SQRT_STAGES];
   logic [15:0] yr_ff  [SQRT_STAGES];
   logic [14:0] dzr_ff [SQRT_STAGES];

   always_ff @(posedge clock) begin
      xr_ff[0]  <= x1_ff;
      yr_ff[0]  <= y1_ff;
      dzr_ff[0] <= dz1_ff;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         xr_ff[i]  <= xr_ff[i-1];
         yr_ff[i]  <= yr_ff[i-1];
         dzr_ff[i] <= dzr_ff[i-1];
      end
   end

   // scale numerator and denominator
   logic [14:0] dz_r, den_in, num_in;
   logic [15:0] over;
   logic        zero_in;
   logic [30:0] dvd_in, dvd_ff;
   logic [15:0] den_ff, x18_ff, y18_ff, mag18_ff;
   logic        zero18_ff;

   assign dz_r    = dzr_ff[SQRT_STAGES-1];
   assign den_in  = FULL_SCALE - dz_r;
   assign over    = mag - {1'b0, dz_r};
   assign zero_in = (mag < {1'b0, dz_r}) || (mag == 16'd0);
   assign num_in  = zero_in ? 15'd0 :
                    (over > {1'b0, den_in}) ? den_in : over[14:0];
   assign dvd_in  = {1'b0, num_in, 15'b0} - {16'b0, num_in};

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      den_ff    <= {1'b0, den_in};
      zero18_ff <= zero_in;
      x18_ff    <= xr_ff[SQRT_STAGES-1];
      y18_ff    <= yr_ff[SQRT_STAGES-1];
      mag18_ff  <= mag;
   end

   logic [14:0] scale;
   gad_div u_scale (.clock(clock), .dividend(dvd_ff), .divisor(den_ff), .quotient(scale));

   logic [15:0] xs_ff  [DIV_STAGES];
   logic [15:0] ys_ff  [DIV_STAGES];
   logic [15:0] mags_ff[DIV_STAGES];
   logic        zs_ff  [DIV_STAGES];

   always_ff @(posedge clock) begin
      xs_ff[0]   <= x18_ff;
      ys_ff[0]   <= y18_ff;
      mags_ff[0] <= mag18_ff;
      zs_ff[0]   <= zero18_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         xs_ff[i]   <= xs_ff[i-1];
         ys_ff[i]   <= ys_ff[i-1];
         mags_ff[i] <= mags_ff[i-1];
         zs_ff[i]   <= zs_ff[i-1];
      end
   end

   // magnitude times scale
   logic [15:0] xs, ys, ax, ay;
   logic [30:0] prodx_in, prody_in, prodx_ff, prody_ff;
   logic [15:0] mag34_ff;
   logic        negx34_ff, negy34_ff, zero34_ff;

   assign xs       = xs_ff[DIV_STAGES-1];
   assign ys       = ys_ff[DIV_STAGES-1];
   assign ax       = xs[15] ? (~xs + 16'd1) : xs;
   assign ay       = ys[15] ? (~ys + 16'd1) : ys;
   assign prodx_in = {15'b0, ax} * {16'b0, scale};
   assign prody_in = {15'b0, ay} * {16'b0, scale};

   always_ff @(posedge clock) begin
      prodx_ff  <= prodx_in;
      prody_ff  <= prody_in;
      mag34_ff  <= mags_ff[DIV_STAGES-1];
      negx34_ff <= xs[15];
      negy34_ff <= ys[15];
      zero34_ff <= zs_ff[DIV_STAGES-1];
   end

   logic [14:0] qx, qy;
   gad_div u_div_x (.clock(clock), .dividend(prodx_ff), .divisor(mag34_ff), .quotient(qx));
   gad_div u_div_y (.clock(clock), .dividend(prody_ff), .divisor(mag34_ff), .quotient(qy));

   logic negx_ff [DIV_STAGES];
   logic negy_ff [DIV_STAGES];
   logic zq_ff   [DIV_STAGES];

   always_ff @(posedge clock) begin
      negx_ff[0] <= negx34_ff;
      negy_ff[0] <= negy34_ff;
      zq_ff[0]   <= zero34_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         negx_ff[i] <= negx_ff[i-1];
         negy_ff[i] <= negy_ff[i-1];
         zq_ff[i]   <= zq_ff[i-1];
      end
   end

   // restore sign, force zero inside the deadzone
   logic signed [15:0] outx_in, outy_in, outx_ff, outy_ff;

   assign outx_in = zq_ff[DIV_STAGES-1] ? 16'sd0 :
                    negx_ff[DIV_STAGES-1] ? $signed(16'd0 - {1'b0, qx}) : $signed({1'b0, qx});
   assign outy_in = zq_ff[DIV_STAGES-1] ? 16'sd0 :
                    negy_ff[DIV_STAGES-1] ? $signed(16'd0 - {1'b0, qy}) : $signed({1'b0, qy});

   always_ff @(posedge clock) begin
      outx_ff <= outx_in;
      outy_ff <= outy_in;
   end

   assign out_x = outx_ff;
   assign out_y = outy_ff;

endmodule

[rtl/core/gad_trigger_lane.sv]
// One trigger lane: threshold, linear rescale to 0..32767, padded to stick latency.
// Depends on gad_pkg and gad_div.
`timescale 1ns / 1ps

module gad_trigger_lane import gad_pkg::*; (
   input  logic        clock,
   input  logic [7:0]  level,
   input  logic [7:0]  threshold,
   output logic [14:0] level_out
);

   logic [7:0]  th, span;
   logic        zero_in, zero1_ff;
   logic [30:0] dvd_in, dvd_ff;
   logic [15:0] den_in, den_ff;

   // span above threshold times full scale
   assign th      = (threshold == TRIG_MAX) ? TH_MAX : threshold;
   assign zero_in = level < th;
   assign span    = zero_in ? 8'd0 : (level - th);
   assign dvd_in  = {8'b0, span, 15'b0} - {23'b0, span};
   assign den_in  = {8'b0, TRIG_MAX - th};

   always_ff @(posedge clock) begin
      dvd_ff   <= dvd_in;
      den_ff   <= den_in;
      zero1_ff <= zero_in;
   end

   logic [14:0] q;
   gad_div u_div (.clock(clock), .dividend(dvd_ff), .divisor(den_ff), .quotient(q));

   logic zd_ff [DIV_STAGES];
   always_ff @(posedge clock) begin
      zd_ff[0] <= zero1_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         zd_ff[i] <= zd_ff[i-1];
      end
   end

   // hold the result until the stick lanes catch up
   logic [14:0] out_ff;
   logic [14:0] pad_ff [TRIG_PAD];

   always_ff @(posedge clock) begin
      out_ff    <= zd_ff[DIV_STAGES-1] ? 15'd0 : q;
      pad_ff[0] <= out_ff;
      for (int i = 1; i < TRIG_PAD; i++) begin
         pad_ff[i] <= pad_ff[i-1];
      end
   end

   assign level_out = pad_ff[TRIG_PAD-1];

endmodule

[rtl/core/gamepad_analog_deadzone.sv]
// Top level: registers, two stick lanes, two trigger lanes and the merge register.
// Depends on gad_pkg, gad_stick_lane and gad_trigger_lane.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start && !busy
//   response  rsp_strobe, rsp_data           one cycle, no back-pressure
//   config    csr_we, csr_index, csr_wdata   written when csr_we
//
// One item enters every cycle that busy is low; results leave in the order taken.
// The stick path runs through the 16-stage root and the two 15-stage dividers in series.
// busy is high during reset and in the first cycle after it; reset drops items in flight.
// The receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps

module gamepad_analog_deadzone import gad_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    busy_ff;
   logic    accept;
   logic    valid_ff [PIPE_LAT];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_dz  <= LEFT_DZ_RST;
         cfg_ff.right_dz <= RIGHT_DZ_RST;
         cfg_ff.trig_th  <= TRIG_TH_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_DZ:  cfg_ff.left_dz  <= csr_wdata;
            CSR_RIGHT_DZ: cfg_ff.right_dz <= csr_wdata;
            CSR_TRIG_TH:  cfg_ff.trig_th  <= csr_wdata[7:0];
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   // hold off items in the first cycle out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // advance item valid alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i < PIPE_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // lanes
   rsp_type lane_out;

   gad_stick_lane u_left (
      .clock(clock), .axis_x(req_data.left_x), .axis_y(req_data.left_y),
      .deadzone(cfg_ff.left_dz), .out_x(lane_out.left_out_x), .out_y(lane_out.left_out_y)
   );

   gad_stick_lane u_right (
      .clock(clock), .axis_x(req_data.right_x), .axis_y(req_data.right_y),
      .deadzone(cfg_ff.right_dz), .out_x(lane_out.right_out_x),
      .out_y(lane_out.right_out_y)
   );

   gad_trigger_lane u_ltrig (
      .clock(clock), .level(req_data.left_trigger), .threshold(cfg_ff.trig_th),
      .level_out(lane_out.left_trigger_out)
   );

   gad_trigger_lane u_rtrig (
      .clock(clock), .level(req_data.right_trigger), .threshold(cfg_ff.trig_th),
      .level_out(lane_out.right_trigger_out)
   );

   // merge the lanes into the result register
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      rsp_ff <= lane_out;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = valid_ff[PIPE_LAT-1];

   // every result comes from an item that was taken
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, PIPE_LAT))
      else $error("result without a matching item");

   // a fully pressed left trigger reads full scale whatever the threshold
   a_trig_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.left_trigger, PIPE_LAT) == TRIG_MAX)
      |-> rsp_data.left_trigger_out == FULL_SCALE)
      else $error("full trigger not at full scale");

   // a centered right stick reads zero on both axes
   a_stick_center: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.right_x, PIPE_LAT) == 16'sd0
                  && $past(req_data.right_y, PIPE_LAT) == 16'sd0)
      |-> (rsp_data.right_out_x == 16'sd0 && rsp_data.right_out_y == 16'sd0))
      else $error("centered stick not zero");

endmodule

[test/testbench.sv]
// Self-checking testbench for gamepad_analog_deadzone: radial stick deadzone and trigger scaling.
// Depends on gad_pkg and the RTL top level; predicts each result and compares field by field.
`timescale 1ns / 1ps

module testbench;
   import gad_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = CSR_LEFT_DZ;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   // Predictor copy of the register file
   logic [14:0] left_dz_q;
   logic [14:0] right_dz_q;
   logic [7:0]  trig_th_q;

   rsp_type expected_q[$];
   int      error_count = 0;
   int      result_count = 0;
   int      item_count = 0;
   int      send_idle_pct = 0;

   gamepad_analog_deadzone uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Floor square root by bit-by-bit refinement
   function automatic logic [31:0] floor_root(input logic [31:0] v);
      logic [31:0] res;
      logic [31:0] b;
      res = 0;
      b = 32'h4000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Radial deadzone scaling of one stick
   function automatic void scale_stick(input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input logic [14:0] dz_in,
                                       output logic signed [15:0] ox,
                                       output logic signed [15:0] oy);
      longint sx, sy, mag, dz, den, num, scl;
      sx = x;
      sy = y;
      mag = floor_root(32'(sx * sx + sy * sy));
      dz = (dz_in > 32766) ? 32766 : dz_in;
      if (mag < dz || mag == 0) begin
         ox = 0;
         oy = 0;
      end else begin
         den = 32767 - dz;
         num = mag - dz;
         if (num > den) num = den;
         scl = (num * 32767) / den;
         ox = 16'((sx * scl) / mag);
         oy = 16'((sy * scl) / mag);
      end
   endfunction

   function automatic logic [14:0] scale_trigger(input logic [7:0] t, input logic [7:0] th_in);
      int th;
      th = (th_in > 254) ? 254 : th_in;
      if (t < th) return 0;
      return 15'(((int'(t) - th) * 32767) / (255 - th));
   endfunction

   function automatic rsp_type normalize_sample(input req_type r);
      rsp_type o;
      scale_stick(r.left_x, r.left_y, left_dz_q, o.left_out_x, o.left_out_y);
      scale_stick(r.right_x, r.right_y, right_dz_q, o.right_out_x, o.right_out_y);
      o.left_trigger_out = scale_trigger(r.left_trigger, trig_th_q);
      o.right_trigger_out = scale_trigger(r.right_trigger, trig_th_q);
      return o;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [14:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEFT_DZ: left_dz_q = val;
         CSR_RIGHT_DZ: right_dz_q = val;
         default: trig_th_q = val[7:0];
      endcase
   endtask

   task automatic set_deadzones(input logic [14:0] l, input logic [14:0] r, input logic [7:0] th);
      write_reg(CSR_LEFT_DZ, l);
      write_reg(CSR_RIGHT_DZ, r);
      write_reg(CSR_TRIG_TH, {7'd0, th});
   endtask

   // Drive one item at the falling edge and hold it until accepted
   task automatic send_sample(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(normalize_sample(r));
      item_count++;
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      start <= 1'b0;
      wait (expected_q.size() == 0);
      repeat (PIPE_LAT + 4) @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'($urandom_range(4000)) - 16'sd2000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type rand_sample();
      req_type r;
      r.left_x = rand_axis();
      r.left_y = rand_axis();
      r.right_x = rand_axis();
      r.right_y = rand_axis();
      r.left_trigger = 8'($urandom);
      r.right_trigger = ($urandom_range(3) == 0) ? 8'hff : 8'($urandom);
      return r;
   endfunction

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            e = expected_q.pop_front();
            result_count++;
            if (rsp_data.left_out_x !== e.left_out_x)
               $display("%0t: left_out_x expected %0d actual %0d", $time,
                        e.left_out_x, rsp_data.left_out_x);
            if (rsp_data.left_out_y !== e.left_out_y)
               $display("%0t: left_out_y expected %0d actual %0d", $time,
                        e.left_out_y, rsp_data.left_out_y);
            if (rsp_data.right_out_x !== e.right_out_x)
               $display("%0t: right_out_x expected %0d actual %0d", $time,
                        e.right_out_x, rsp_data.right_out_x);
            if (rsp_data.right_out_y !== e.right_out_y)
               $display("%0t: right_out_y expected %0d actual %0d", $time,
                        e.right_out_y, rsp_data.right_out_y);
            if (rsp_data.left_trigger_out !== e.left_trigger_out)
               $display("%0t: left_trigger_out expected %0d actual %0d", $time,
                        e.left_trigger_out, rsp_data.left_trigger_out);
            if (rsp_data.right_trigger_out !== e.right_trigger_out)
               $display("%0t: right_trigger_out expected %0d actual %0d", $time,
                        e.right_trigger_out, rsp_data.right_trigger_out);
            if (rsp_data !== e) error_count++;
         end
      end
   end

   // Directed samples: extremes, deadzone edges, centered stick, trigger edges
   typedef struct {
      req_type sample;
      bit      known;
      rsp_type result;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 8'd0}, 1'b1,
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 15'd0, 15'd0}},
      '{'{16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 8'd255, 8'd255}, 1'b1,
        '{16'sd32767, 16'sd0, -16'sd32767, 16'sd0, 15'd32767, 15'd32767}},
      '{'{16'sd0, 16'sd32767, 16'sd0, -16'sd32767, 8'd30, 8'd29}, 1'b1,
        '{16'sd0, 16'sd32767, 16'sd0, -16'sd32767, 15'd0, 15'd0}},
      '{'{16'sd7848, 16'sd0, 16'sd0, 16'sd8688, 8'd1, 8'd254}, 1'b0, '{default: '0}},
      '{'{16'sd7849, 16'sd0, 16'sd0, 16'sd8689, 8'd128, 8'd31}, 1'b0, '{default: '0}},
      '{'{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767, 8'd200, 8'd100}, 1'b0,
        '{default: '0}},
      '{'{16'sd32767, 16'sd32767, -16'sd1, 16'sd1, 8'd255, 8'd0}, 1'b0, '{default: '0}},
      '{'{16'sd20000, -16'sd15000, 16'sd9000, 16'sd9000, 8'd77, 8'd177}, 1'b0,
        '{default: '0}},
      '{'{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 8'h55, 8'haa}, 1'b0, '{default: '0}}
   };

   // Typed expectations hold for the reset register values only
   task automatic run_directed(input bit check_known);
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample);
         if (check_known && directed_rows[i].known
             && normalize_sample(directed_rows[i].sample) !== directed_rows[i].result) begin
            $display("%0t: directed row %0d expected %h predicted %h", $time, i,
                     directed_rows[i].result, normalize_sample(directed_rows[i].sample));
            error_count++;
         end
      end
   endtask

   initial begin
      left_dz_q = LEFT_DZ_RST;
      right_dz_q = RIGHT_DZ_RST;
      trig_th_q = TRIG_TH_RST;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Reset values first, then the extremes of every register
      run_directed(1'b1);
      drain_pipe();
      set_deadzones(15'd0, 15'd32767, 8'd255);
      run_directed(1'b0);
      drain_pipe();
      set_deadzones(15'd32766, 15'd0, 8'd0);
      run_directed(1'b0);
      drain_pipe();
      set_deadzones(15'd1, 15'd32766, 8'd254);
      run_directed(1'b0);

      // Random phases: light sender gaps, then heavy gaps, then none
      for (int phase = 0; phase < 6; phase++) begin
         drain_pipe();
         set_deadzones(15'($urandom), 15'($urandom), 8'($urandom));
         send_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 81 : 0;
         repeat (190) send_sample(rand_sample());
      end

      drain_pipe();
      $display("Covered %0d items and %0d results over ten register settings,", item_count,
               result_count);
      $display("including deadzone and threshold extremes and sender gaps.");
      if (error_count == 0)
         $display("[gamepad_analog_deadzone] OK");
      else
         $display("[gamepad_analog_deadzone] ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("[gamepad_analog_deadzone] ERROR");
      $finish;
   end

endmodule

[files.f]
rtl/core/gad_pkg.sv
rtl/core/gad_isqrt.sv
rtl/core/gad_div.sv
rtl/core/gad_stick_lane.sv
rtl/core/gad_trigger_lane.sv
rtl/core/gamepad_analog_deadzone.sv
test/testbench.sv
